// ===== rtl/core/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg
// Shared sizes, codes and beat types for the lottery ticket scheduler.
// ----------------------------------------------------------------------------
package lts_pkg;

    // table geometry
    localparam int SLOTS       = 64;
    localparam int TICKET_BITS = 16;

    localparam int SLOT_AW = $clog2(SLOTS);
    localparam int SLOT_CW = $clog2(SLOTS + 1);
    localparam int SUM_W   = TICKET_BITS + SLOT_AW;

    // fixed field widths of the beats
    localparam int SLOT_W = 6;
    localparam int TK_W   = 16;
    localparam int WIN_W  = 32;
    localparam int RND_W  = 32;
    localparam int DIV_CW = $clog2(RND_W + 1);

    localparam logic [31:0] TICKET_MAX = 32'((64'd1 << TICKET_BITS) - 64'd1);

    // operation codes
    localparam logic [1:0] FUNC_SET   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_DRAW  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_TICKETS = 2'd1;
    localparam logic [1:0] ST_EMPTY       = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [SLOT_W-1:0] slot;
        logic              runnable;
        logic [TK_W-1:0]   tickets;
        logic [RND_W-1:0]  random_word;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] winner;
        logic [WIN_W-1:0]  winner_wins;
    } rsp_t;

    // table write source
    typedef enum logic [1:0] {
        WR_INIT,
        WR_SET,
        WR_CLEAR,
        WR_WIN
    } wr_src_t;

    // kind of result to build
    typedef enum logic [1:0] {
        RES_OK,
        RES_BAD,
        RES_EMPTY,
        RES_WIN
    } res_kind_t;

    typedef struct packed {
        logic      load;
        logic      idx_clr;
        logic      idx_inc;
        logic      rd_en;
        logic      acc_clr;
        logic      acc_en;
        logic      div_start;
        logic      div_step;
        logic      win_latch;
        logic      wr_en;
        wr_src_t   wr_src;
        logic      res_load;
        res_kind_t res_kind;
        logic      out_load;
    } lts_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       tk_zero;
        logic       slot_ok;
        logic       idx_end;
        logic       sweep_done;
        logic       acc_zero;
        logic       div_done;
        logic       hit;
        logic       out_free;
    } lts_sts_t;

endpackage

// ===== rtl/core/lts_dp.sv =====
// ----------------------------------------------------------------------------
// lts_dp
// Slot tables, ticket accumulator, serial divider and result registers.
// ----------------------------------------------------------------------------
module lts_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  lts_pkg::lts_cmd_t cmd,
    output lts_pkg::lts_sts_t sts,
    input  lts_pkg::req_t     req_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output lts_pkg::rsp_t     rsp_data
);
    import lts_pkg::*;

    typedef struct packed {
        logic                   run;
        logic [TICKET_BITS-1:0] tk;
    } sched_ent_t;

    sched_ent_t       sched_mem [SLOTS];
    logic [WIN_W-1:0] win_mem   [SLOTS];

    req_t               item_reg;
    logic [SLOT_CW-1:0] idx_reg;
    logic               rd_valid_reg;
    logic [SLOT_AW-1:0] rd_idx_reg;
    sched_ent_t         sched_rd_reg;
    logic [WIN_W-1:0]   win_rd_reg;
    logic [SUM_W-1:0]   acc_reg;
    logic [SUM_W-1:0]   acc_next;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   rem_reg;
    logic [SUM_W-1:0]   rem_next;
    logic [RND_W-1:0]   rnd_sh_reg;
    logic [DIV_CW-1:0]  div_cnt_reg;
    logic [SLOT_AW-1:0] win_idx_reg;
    rsp_t               res_reg;
    rsp_t               out_reg;
    logic               out_valid_reg;

    logic [SUM_W:0]         rem_sh;
    logic [SUM_W:0]         rem_diff;
    logic [31:0]            tk_wide;
    logic [TICKET_BITS-1:0] tk_sat;
    logic [SLOT_AW-1:0]     slot_addr;
    logic [SLOT_AW-1:0]     wr_addr;
    logic                   sched_we;
    logic                   win_we;
    sched_ent_t             sched_wdata;
    logic [WIN_W-1:0]       win_wdata;
    logic [WIN_W-1:0]       wins_inc;

    // clamp tickets to the table width
    assign tk_wide   = 32'(item_reg.tickets);
    assign tk_sat    = (tk_wide > TICKET_MAX) ? TICKET_BITS'(TICKET_MAX)
                                              : TICKET_BITS'(tk_wide);
    assign slot_addr = SLOT_AW'(item_reg.slot);
    assign wins_inc  = win_rd_reg + WIN_W'(1);

    always_comb
    begin
        sched_we    = cmd.wr_en && (cmd.wr_src inside {WR_INIT, WR_SET, WR_CLEAR});
        win_we      = cmd.wr_en && (cmd.wr_src inside {WR_INIT, WR_CLEAR, WR_WIN});
        sched_wdata = '{run: 1'b0, tk: TICKET_BITS'(1)};
        win_wdata   = '0;
        wr_addr     = slot_addr;
        case (cmd.wr_src)
            WR_INIT:
            begin
                wr_addr = idx_reg[SLOT_AW-1:0];
            end
            WR_SET:
            begin
                sched_wdata = '{run: item_reg.runnable, tk: tk_sat};
            end
            WR_WIN:
            begin
                wr_addr   = win_idx_reg;
                win_wdata = wins_inc;
            end
            default:
            begin
                wr_addr = slot_addr;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (sched_we)
        begin
            sched_mem[wr_addr] <= sched_wdata;
        end
        if (cmd.rd_en)
        begin
            sched_rd_reg <= sched_mem[idx_reg[SLOT_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[wr_addr] <= win_wdata;
        end
        win_rd_reg <= win_mem[win_idx_reg];
    end

    // accumulate runnable tickets of the entry read last cycle
    assign acc_next = acc_reg + (sched_rd_reg.run ? SUM_W'(sched_rd_reg.tk) : '0);

    // one restoring division step per cycle
    assign rem_sh   = {rem_reg, rnd_sh_reg[RND_W-1]};
    assign rem_diff = rem_sh - {1'b0, sum_reg};
    assign rem_next = rem_diff[SUM_W] ? rem_sh[SUM_W-1:0] : rem_diff[SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + SLOT_CW'(1);
            end
            if (cmd.div_start)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req_data;
        end
        if (cmd.rd_en)
        begin
            rd_idx_reg <= idx_reg[SLOT_AW-1:0];
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en && rd_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.div_start)
        begin
            sum_reg    <= acc_reg;
            rem_reg    <= '0;
            rnd_sh_reg <= item_reg.random_word;
        end
        else if (cmd.div_step)
        begin
            rem_reg    <= rem_next;
            rnd_sh_reg <= {rnd_sh_reg[RND_W-2:0], 1'b0};
        end
        if (cmd.win_latch)
        begin
            win_idx_reg <= rd_idx_reg;
        end
        if (cmd.res_load)
        begin
            case (cmd.res_kind)
                RES_BAD:   res_reg <= '{status: ST_BAD_TICKETS, winner: '0, winner_wins: '0};
                RES_EMPTY: res_reg <= '{status: ST_EMPTY, winner: '0, winner_wins: '0};
                RES_WIN:   res_reg <= '{status: ST_OK, winner: SLOT_W'(win_idx_reg),
                                        winner_wins: wins_inc};
                default:   res_reg <= '{status: ST_OK, winner: '0, winner_wins: '0};
            endcase
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    always_comb
    begin
        sts.func       = item_reg.func;
        sts.tk_zero    = (item_reg.tickets == '0);
        sts.slot_ok    = (32'(item_reg.slot) < 32'(SLOTS));
        sts.idx_end    = (idx_reg == SLOT_CW'(SLOTS));
        sts.sweep_done = sts.idx_end && !rd_valid_reg;
        sts.acc_zero   = (acc_reg == '0);
        sts.div_done   = (div_cnt_reg == DIV_CW'(RND_W));
        sts.hit        = rd_valid_reg && sched_rd_reg.run && (acc_next > rem_reg);
        sts.out_free   = !out_valid_reg || rsp_ready;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

// ===== rtl/core/lts_ctrl.sv =====
// ----------------------------------------------------------------------------
// lts_ctrl
// Sequencer for table init, set/clear, and the sum/divide/search draw.
// ----------------------------------------------------------------------------
module lts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  lts_pkg::lts_sts_t sts,
    output lts_pkg::lts_cmd_t cmd
);
    import lts_pkg::*;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_SUM,
        S_DIV,
        S_SEARCH,
        S_WIN_RD,
        S_WIN_WR,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                // sweep reset values into every slot
                if (sts.idx_end)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_src  = WR_INIT;
                    cmd.idx_inc = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.res_load = 1'b1;
                cmd.res_kind = RES_OK;
                state_next   = S_DONE;
                case (sts.func)
                    FUNC_SET:
                    begin
                        if (sts.tk_zero)
                        begin
                            cmd.res_kind = RES_BAD;
                        end
                        else if (sts.slot_ok)
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_src = WR_SET;
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        if (sts.slot_ok)
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_src = WR_CLEAR;
                        end
                    end
                    FUNC_DRAW:
                    begin
                        cmd.res_load = 1'b0;
                        cmd.idx_clr  = 1'b1;
                        cmd.acc_clr  = 1'b1;
                        state_next   = S_SUM;
                    end
                    default:
                    begin
                        cmd.res_kind = RES_OK;
                    end
                endcase
            end
            S_SUM:
            begin
                cmd.rd_en   = !sts.idx_end;
                cmd.idx_inc = !sts.idx_end;
                cmd.acc_en  = 1'b1;
                if (sts.sweep_done)
                begin
                    if (sts.acc_zero)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_kind = RES_EMPTY;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.idx_clr = 1'b1;
                    cmd.acc_clr = 1'b1;
                    state_next  = S_SEARCH;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_SEARCH:
            begin
                cmd.rd_en   = !sts.idx_end;
                cmd.idx_inc = !sts.idx_end;
                cmd.acc_en  = 1'b1;
                if (sts.hit)
                begin
                    cmd.win_latch = 1'b1;
                    state_next    = S_WIN_RD;
                end
                else if (sts.sweep_done)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_EMPTY;
                    state_next   = S_DONE;
                end
            end
            S_WIN_RD:
            begin
                state_next = S_WIN_WR;
            end
            S_WIN_WR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_src   = WR_WIN;
                cmd.res_load = 1'b1;
                cmd.res_kind = RES_WIN;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/lottery_ticket_scheduler.sv =====
// ----------------------------------------------------------------------------
// lottery_ticket_scheduler
// Lottery arbiter over SLOTS requester slots, each with a runnable flag, a
// ticket count and a wrapping 32-bit win count. One beat in gives one beat
// out. After reset the block sweeps reset values through its slot tables
// with req_ready low. The block works on one request at a time. A draw
// walks the table once to sum the runnable tickets (one table read per
// cycle), runs a one-bit-per-cycle restoring divider for random_word mod
// sum, then walks the table again until the running sum passes the
// remainder, and then updates the win count of the winner and presents
// the result. A draw that finds no tickets ends after the first walk.
// The result beat sits in an output register, so the next request is
// taken while it waits for rsp_ready.
// ----------------------------------------------------------------------------
module lottery_ticket_scheduler (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  lts_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output lts_pkg::rsp_t rsp_data
);
    import lts_pkg::*;

    lts_cmd_t cmd;
    lts_sts_t sts;

    // sequencer: decides each cycle which datapath step runs
    lts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // tables, accumulator, divider and output register
    lts_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    // a rejected set never touches the table, and only in-range slots are written
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && cmd.wr_src == WR_SET) |-> (!sts.tk_zero && sts.slot_ok))
        else $error("set write with zero tickets or out-of-range slot");

    // never overwrite a result beat that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp_valid || rsp_ready))
        else $error("result register overwritten while still pending");

    // winner fields are zero unless the status is ok
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.status != ST_OK)
            |-> (rsp_data.winner == '0 && rsp_data.winner_wins == '0))
        else $error("winner fields set on an error result");

    // hold off the next request once one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !req_ready)
        else $error("request accepted while another is in progress");

endmodule
